### rtl/core/clbs_pkg.sv
// Shared types and constants for the curve lookup block.
// Used by clbs_ctrl, clbs_dp and curve_lerp_binary_search_unit.
`timescale 1ns / 1ps
package clbs_pkg;

  localparam int MaxPoints = 64;
  localparam int AddrW     = $clog2(MaxPoints);
  localparam int CountW    = 7;
  localparam int ChargeW   = 32;
  localparam int VoltW     = 24;
  localparam int DivW      = VoltW + ChargeW;
  localparam int DivCntW   = $clog2(DivW);

  localparam logic       OP_LOAD      = 1'b0;
  localparam logic       OP_QUERY     = 1'b1;
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_BELOW = 2'd1;
  localparam logic [1:0] STATUS_ABOVE = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_FIRST, S_LAST, S_W1, S_W2, S_W0, S_W3, S_WCHK,
    S_BS, S_BM, S_F0, S_F1, S_F2, S_F3, S_DIV, S_MUL_LO, S_MUL_HI,
    S_SUM, S_OUT
  } state_t;

  typedef enum logic [3:0] {
    RD_ZERO, RD_LAST, RD_CUR, RD_CUR_P1, RD_CUR_M1, RD_CUR_P2,
    RD_MID, RD_SEG, RD_SEG_P1
  } rd_sel_t;

  typedef enum logic [2:0] {
    CAP_NONE, CAP_W0, CAP_W1, CAP_W2, CAP_W3, CAP_P0, CAP_P1
  } cap_sel_t;

  typedef enum logic [2:0] {
    SEG_NONE, SEG_CUR, SEG_CUR_M1, SEG_CUR_P1, SEG_LO, SEG_MID
  } seg_sel_t;

  typedef enum logic [2:0] {
    RES_NONE, RES_BELOW, RES_ABOVE, RES_V0, RES_V1, RES_INTERP
  } res_sel_t;

  typedef struct packed {
    logic     load_wr;
    logic     q_take;
    rd_sel_t  rd_sel;
    cap_sel_t cap_sel;
    seg_sel_t seg_sel;
    logic     bs_init;
    logic     bs_step;
    logic     div_start;
    logic     div_step;
    logic     mul_lo;
    logic     mul_hi;
    res_sel_t res_sel;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic below;
    logic above;
    logic cur_ok;
    logic hit_cur;
    logic hit_m1;
    logic hit_p1;
    logic bs_done;
    logic bs_eq;
    logic q_eq_c0;
    logic q_eq_c1;
    logic c_bad;
    logic div_last;
    logic out_busy;
  } dp_stat_t;

endpackage

### rtl/core/curve_lerp_binary_search_unit.sv
// A load writes memory from idle; a query off the curve ends at the first or last point
// check, and one inside it runs a window check or binary search and may then divide.
// One item at a time; the 1-bit-per-cycle slope divider sets the worst case.
// The result register lets the next item enter while a result waits.
// Reset (rst_n, synchronous): point count 2, no cached segment, no result pending;
// breakpoint memory is not cleared.
`timescale 1ns / 1ps
module curve_lerp_binary_search_unit
  import clbs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_opcode,
  input  logic [AddrW-1:0]   in_point_index,
  input  logic [ChargeW-1:0] in_point_charge,
  input  logic [VoltW-1:0]   in_point_voltage,
  input  logic [ChargeW-1:0] in_query_charge,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [VoltW-1:0]   out_voltage,
  output logic [1:0]         out_status,
  input  logic               cfg_we,
  input  logic [CountW-1:0]  cfg_wdata
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  clbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  clbs_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_point_index   (in_point_index),
    .in_point_charge  (in_point_charge),
    .in_point_voltage (in_point_voltage),
    .in_query_charge  (in_query_charge),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_voltage      (out_voltage),
    .out_status       (out_status)
  );

endmodule

### rtl/core/clbs_dp.sv
// Datapath: breakpoint memory, cursor, search bounds, divider, multiplier, output register.
// Depends on clbs_pkg; driven by clbs_ctrl commands.
`timescale 1ns / 1ps
module clbs_dp
  import clbs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  ctrl_cmd_t           cmd,
  output dp_stat_t            stat,
  input  logic [AddrW-1:0]    in_point_index,
  input  logic [ChargeW-1:0]  in_point_charge,
  input  logic [VoltW-1:0]    in_point_voltage,
  input  logic [ChargeW-1:0]  in_query_charge,
  input  logic                cfg_we,
  input  logic [CountW-1:0]   cfg_wdata,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [VoltW-1:0]    out_voltage,
  output logic [1:0]          out_status
);

  logic [ChargeW+VoltW-1:0] mem [MaxPoints];
  logic [ChargeW+VoltW-1:0] rd_data_r;
  logic [AddrW-1:0]         rd_addr;

  logic [CountW-1:0]  point_count_r;
  logic [CountW-1:0]  n_used;
  logic [AddrW-1:0]   cur_r;
  logic               cur_valid_r;
  logic [ChargeW-1:0] q_r;
  logic [ChargeW-1:0] w0_r, w1_r, w2_r, w3_r;
  logic [ChargeW-1:0] c0_r, c1_r;
  logic [VoltW-1:0]   v0_r, v1_r;
  logic [AddrW-1:0]   lo_r, hi_r, seg_r, mid;
  logic [DivW-1:0]    dvd_r;
  logic [ChargeW-1:0] rem_r;
  logic [DivCntW-1:0] div_cnt_r;
  logic [VoltW-1:0]   prod_lo_r, prod_hi_r;
  logic [VoltW-1:0]   res_volt_r;
  logic [1:0]         res_stat_r;
  logic               out_valid_r;
  logic [VoltW-1:0]   out_voltage_r;
  logic [1:0]         out_status_r;

  logic [ChargeW-1:0] rd_charge;
  logic [VoltW-1:0]   rd_volt;
  logic               up;
  logic [VoltW-1:0]   dv, off;
  logic [ChargeW-1:0] dc, dq;
  logic [ChargeW:0]   rem_ext;
  logic               rem_ge;
  logic [2*ChargeW-1:0] prod_lo_full;
  logic [2*VoltW-1:0]   prod_hi_full;

  assign rd_charge = rd_data_r[ChargeW+VoltW-1:VoltW];
  assign rd_volt   = rd_data_r[VoltW-1:0];

  always_comb begin
    if (point_count_r < CountW'(2)) begin
      n_used = CountW'(2);
    end else if (point_count_r > CountW'(MaxPoints)) begin
      n_used = CountW'(MaxPoints);
    end else begin
      n_used = point_count_r;
    end
  end

  assign mid = lo_r + ((hi_r - lo_r) >> 1);

  always_comb begin
    unique case (cmd.rd_sel)
      RD_ZERO:   rd_addr = '0;
      RD_LAST:   rd_addr = AddrW'(n_used - CountW'(1));
      RD_CUR:    rd_addr = cur_r;
      RD_CUR_P1: rd_addr = cur_r + AddrW'(1);
      RD_CUR_M1: rd_addr = cur_r - AddrW'(1);
      RD_CUR_P2: rd_addr = cur_r + AddrW'(2);
      RD_MID:    rd_addr = mid;
      RD_SEG:    rd_addr = seg_r;
      RD_SEG_P1: rd_addr = seg_r + AddrW'(1);
      default:   rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      mem[in_point_index] <= {in_point_charge, in_point_voltage};
    end
    rd_data_r <= mem[rd_addr];
  end

  // interpolation arithmetic
  assign up  = v1_r >= v0_r;
  assign dv  = up ? (v1_r - v0_r) : (v0_r - v1_r);
  assign dc  = c1_r - c0_r;
  assign dq  = q_r - c0_r;
  assign rem_ext = {rem_r, dvd_r[DivW-1]};
  assign rem_ge  = rem_ext >= {1'b0, dc};
  assign prod_lo_full = dq * dvd_r[ChargeW-1:0];
  assign prod_hi_full = dq[VoltW-1:0] * dvd_r[DivW-1:ChargeW];
  assign off = prod_hi_r + prod_lo_r;

  always_ff @(posedge clk) begin
    if (cmd.q_take) begin
      q_r <= in_query_charge;
    end
    case (cmd.cap_sel)
      CAP_W0: w0_r <= rd_charge;
      CAP_W1: w1_r <= rd_charge;
      CAP_W2: w2_r <= rd_charge;
      CAP_W3: w3_r <= rd_charge;
      CAP_P0: begin
        c0_r <= rd_charge;
        v0_r <= rd_volt;
      end
      CAP_P1: begin
        c1_r <= rd_charge;
        v1_r <= rd_volt;
      end
      default: ;
    endcase
    if (cmd.bs_init) begin
      lo_r <= '0;
      hi_r <= AddrW'(n_used - CountW'(1));
    end else if (cmd.bs_step) begin
      if (q_r < rd_charge) begin
        hi_r <= mid;
      end else begin
        lo_r <= mid;
      end
    end
    case (cmd.seg_sel)
      SEG_CUR:    seg_r <= cur_r;
      SEG_CUR_M1: seg_r <= cur_r - AddrW'(1);
      SEG_CUR_P1: seg_r <= cur_r + AddrW'(1);
      SEG_LO:     seg_r <= lo_r;
      SEG_MID:    seg_r <= mid;
      default: ;
    endcase
    // restoring divide, one quotient bit per cycle, quotient shifts into dvd_r
    if (cmd.div_start) begin
      dvd_r     <= {dv, ChargeW'(0)};
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r     <= rem_ge ? ChargeW'(rem_ext - {1'b0, dc}) : rem_ext[ChargeW-1:0];
      dvd_r     <= {dvd_r[DivW-2:0], rem_ge};
      div_cnt_r <= div_cnt_r + DivCntW'(1);
    end
    if (cmd.mul_lo) begin
      prod_lo_r <= prod_lo_full[ChargeW+VoltW-1:ChargeW];
    end
    if (cmd.mul_hi) begin
      prod_hi_r <= prod_hi_full[VoltW-1:0];
    end
    case (cmd.res_sel)
      RES_BELOW: begin
        res_volt_r <= '0;
        res_stat_r <= STATUS_BELOW;
      end
      RES_ABOVE: begin
        res_volt_r <= '0;
        res_stat_r <= STATUS_ABOVE;
      end
      RES_V0: begin
        res_volt_r <= v0_r;
        res_stat_r <= STATUS_OK;
      end
      RES_V1: begin
        res_volt_r <= v1_r;
        res_stat_r <= STATUS_OK;
      end
      RES_INTERP: begin
        res_volt_r <= up ? (v0_r + off) : (v0_r - off);
        res_stat_r <= STATUS_OK;
      end
      default: ;
    endcase
    if (cmd.out_load) begin
      out_voltage_r <= res_volt_r;
      out_status_r  <= res_stat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= CountW'(2);
      cur_r         <= '0;
      cur_valid_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        point_count_r <= cfg_wdata;
      end
      if (cfg_we || cmd.load_wr) begin
        cur_valid_r <= 1'b0;
      end else if (cmd.out_load && res_stat_r == STATUS_OK) begin
        cur_valid_r <= 1'b1;
        cur_r       <= seg_r;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.below    = q_r < rd_charge;
    stat.above    = q_r > rd_charge;
    stat.cur_ok   = cur_valid_r && ({1'b0, cur_r} + CountW'(1) < n_used);
    stat.hit_cur  = w1_r <= q_r && q_r <= w2_r;
    stat.hit_m1   = cur_r != '0 && w0_r <= q_r && q_r <= w1_r;
    stat.hit_p1   = ({1'b0, cur_r} + CountW'(2) < n_used) && w2_r <= q_r && q_r <= w3_r;
    stat.bs_done  = (hi_r - lo_r) <= AddrW'(1);
    stat.bs_eq    = q_r == rd_charge;
    stat.q_eq_c0  = q_r == c0_r;
    stat.q_eq_c1  = q_r == c1_r;
    stat.c_bad    = c1_r <= c0_r;
    stat.div_last = div_cnt_r == DivCntW'(DivW - 1);
    stat.out_busy = out_valid_r && !out_ready;
  end

  assign out_valid   = out_valid_r;
  assign out_voltage = out_voltage_r;
  assign out_status  = out_status_r;

endmodule

### rtl/core/clbs_ctrl.sv
// Controller state machine: sequences breakpoint writes, memory reads, search, divide, multiply and output.
// Depends on clbs_pkg; commands clbs_dp.
`timescale 1ns / 1ps
module clbs_ctrl
  import clbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_opcode,
  output logic       in_ready,
  input  dp_stat_t   stat,
  output ctrl_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd.load_wr   = 1'b0;
    cmd.q_take    = 1'b0;
    cmd.rd_sel    = RD_ZERO;
    cmd.cap_sel   = CAP_NONE;
    cmd.seg_sel   = SEG_NONE;
    cmd.bs_init   = 1'b0;
    cmd.bs_step   = 1'b0;
    cmd.div_start = 1'b0;
    cmd.div_step  = 1'b0;
    cmd.mul_lo    = 1'b0;
    cmd.mul_hi    = 1'b0;
    cmd.res_sel   = RES_NONE;
    cmd.out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_opcode == OP_LOAD) begin
            cmd.load_wr = 1'b1;
          end else begin
            cmd.q_take = 1'b1;
            cmd.rd_sel = RD_ZERO;
            state_nxt  = S_FIRST;
          end
        end
      end
      S_FIRST: begin
        if (stat.below) begin
          cmd.res_sel = RES_BELOW;
          state_nxt   = S_OUT;
        end else begin
          cmd.rd_sel = RD_LAST;
          state_nxt  = S_LAST;
        end
      end
      S_LAST: begin
        if (stat.above) begin
          cmd.res_sel = RES_ABOVE;
          state_nxt   = S_OUT;
        end else if (stat.cur_ok) begin
          cmd.rd_sel = RD_CUR;
          state_nxt  = S_W1;
        end else begin
          cmd.bs_init = 1'b1;
          state_nxt   = S_BS;
        end
      end
      // window of four charges around the cached segment
      S_W1: begin
        cmd.cap_sel = CAP_W1;
        cmd.rd_sel  = RD_CUR_P1;
        state_nxt   = S_W2;
      end
      S_W2: begin
        cmd.cap_sel = CAP_W2;
        cmd.rd_sel  = RD_CUR_M1;
        state_nxt   = S_W0;
      end
      S_W0: begin
        cmd.cap_sel = CAP_W0;
        cmd.rd_sel  = RD_CUR_P2;
        state_nxt   = S_W3;
      end
      S_W3: begin
        cmd.cap_sel = CAP_W3;
        state_nxt   = S_WCHK;
      end
      S_WCHK: begin
        if (stat.hit_cur) begin
          cmd.seg_sel = SEG_CUR;
          state_nxt   = S_F0;
        end else if (stat.hit_m1) begin
          cmd.seg_sel = SEG_CUR_M1;
          state_nxt   = S_F0;
        end else if (stat.hit_p1) begin
          cmd.seg_sel = SEG_CUR_P1;
          state_nxt   = S_F0;
        end else begin
          cmd.bs_init = 1'b1;
          state_nxt   = S_BS;
        end
      end
      S_BS: begin
        if (stat.bs_done) begin
          cmd.seg_sel = SEG_LO;
          state_nxt   = S_F0;
        end else begin
          cmd.rd_sel = RD_MID;
          state_nxt  = S_BM;
        end
      end
      S_BM: begin
        if (stat.bs_eq) begin
          cmd.seg_sel = SEG_MID;
          state_nxt   = S_F0;
        end else begin
          cmd.bs_step = 1'b1;
          state_nxt   = S_BS;
        end
      end
      S_F0: begin
        cmd.rd_sel = RD_SEG;
        state_nxt  = S_F1;
      end
      S_F1: begin
        cmd.cap_sel = CAP_P0;
        cmd.rd_sel  = RD_SEG_P1;
        state_nxt   = S_F2;
      end
      S_F2: begin
        cmd.cap_sel = CAP_P1;
        state_nxt   = S_F3;
      end
      S_F3: begin
        if (stat.q_eq_c0) begin
          cmd.res_sel = RES_V0;
          state_nxt   = S_OUT;
        end else if (stat.q_eq_c1) begin
          cmd.res_sel = RES_V1;
          state_nxt   = S_OUT;
        end else if (stat.c_bad) begin
          cmd.res_sel = RES_V0;
          state_nxt   = S_OUT;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_MUL_LO;
        end
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_SUM;
      end
      S_SUM: begin
        cmd.res_sel = RES_INTERP;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
